/* sv/ambient_light_led_dimmer_top_macros.svh */
// Assertion macros for the ambient light LED dimmer.
// Included by ambient_light_led_dimmer_top.sv; expects clock and reset in scope.
`ifndef AMBIENT_LIGHT_LED_DIMMER_TOP_MACROS_SVH
`define AMBIENT_LIGHT_LED_DIMMER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ALD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ambient_light_led_dimmer_top: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define ALD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ambient_light_led_dimmer_top: next-cycle check failed");

`endif

/* sv/aldim_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the ambient light LED dimmer.
// No dependencies; used by the top level.
package aldim_pkg;

   // Operating modes
   localparam logic [1:0] MODE_SENSE  = 2'd0;
   localparam logic [1:0] MODE_CONST  = 2'd1;
   localparam logic [1:0] MODE_RAMP   = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_DARK_LEVEL   = 2'd0;
   localparam logic [1:0] CSR_BRIGHT_LEVEL = 2'd1;
   localparam logic [1:0] CSR_HYST_WINDOW  = 2'd2;
   localparam logic [1:0] CSR_BREATH_STEP  = 2'd3;

   // Configuration reset values
   localparam logic [6:0] DARK_LEVEL_RST   = 7'd25;
   localparam logic [6:0] BRIGHT_LEVEL_RST = 7'd80;
   localparam logic [6:0] HYST_WINDOW_RST  = 7'd5;
   localparam logic [6:0] BREATH_STEP_RST  = 7'd5;

   // Warm color ratios and percent scale
   localparam int GREEN_NUM = 500;
   localparam int BLUE_NUM  = 250;
   localparam int RATIO_DEN = 999;
   localparam int PCT_SCALE = 100;
   localparam logic [6:0] PCT_FULL = 7'd100;

   typedef struct packed {
      logic [6:0] light_level;
      logic       mode_button;
   } req_type;

   typedef struct packed {
      logic [9:0] red_duty;
      logic [9:0] green_duty;
      logic [9:0] blue_duty;
      logic [1:0] active_mode;
      logic [6:0] level_percent;
   } rsp_type;

endpackage

/* sv/aldim_muldiv.sv */
`timescale 1ns / 1ps
// Shared multiply-then-divide unit: quotient = (op_a * op_m) / op_d.
// One registered multiply, then a restoring divider at one bit per cycle. No dependencies.
module aldim_muldiv #(
   parameter int AW = 10,
   parameter int MW = 10,
   parameter int DW = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [AW-1:0]      op_a,
   input  logic [MW-1:0]      op_m,
   input  logic [DW-1:0]      op_d,
   output logic               busy,
   output logic               done,
   output logic [AW+MW-1:0]   quotient
);

   localparam int PW = AW + MW;
   localparam int CW = $clog2(PW + 1);

   logic [PW-1:0] prod_ff, prod_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [DW:0]   shifted;
   logic [DW:0]   trial;
   logic          take;

   // Trial subtract of the divisor from the partial remainder
   assign shifted = {rem_ff, prod_ff[PW-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign take    = ~trial[DW];

   always_comb begin
      prod_in = prod_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // product lands in the shift register, quotient bits replace it
         prod_in = PW'(op_a) * PW'(op_m);
         rem_in  = '0;
         dvs_in  = op_d;
         cnt_in  = CW'(PW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = {prod_ff[PW-2:0], take};
         rem_in  = take ? trial[DW-1:0] : shifted[DW-1:0];
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = prod_ff;

endmodule

/* sv/ambient_light_led_dimmer_top.sv */
`timescale 1ns / 1ps
// Ambient light LED dimmer: one frame tick in, one set of warm RGB PWM duties out.
// Depends on aldim_pkg, aldim_muldiv and ambient_light_led_dimmer_top_macros.svh.
//
// Each accepted frame first applies the mode key (auto, constant, breathing), then
// runs the frame on a small sequencer around one shared multiply/divide unit that
// retires one quotient bit per cycle over PW = RW + max(RW, 9) bits, where
// RW = clog2(DUTY_TOP + 1). Each divide holds the sequencer through its issue, its
// shifts and the quotient pickup. The auto mapping divide issues in the dispatch state.
// A frame needs 2 divides in auto mode (red, green) plus the mapping divide for a
// reading between the cutoffs, 2 in breathing mode (green, percent) and none in
// constant mode. The done state stretches while the previous result still waits.
// The input is not ready while a frame runs; a finished result waits in an
// output register and the next frame may be accepted before it is taken.

`include "ambient_light_led_dimmer_top_macros.svh"

module ambient_light_led_dimmer_top #(
   parameter int DUTY_TOP = 999
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  aldim_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output aldim_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_addr,
   input  logic [6:0]        csr_wdata
);

   // Datapath widths follow the PWM top value
   localparam int RW = $clog2(DUTY_TOP + 1);
   localparam int MW = (RW > 9) ? RW : 9;
   localparam int DW = (RW > 10) ? RW : 10;
   localparam int PW = RW + MW;
   localparam int BW = RW + 1;

   // Constant mode duties and percent
   localparam int CONST_RED   = DUTY_TOP / 2;
   localparam int CONST_GREEN = (DUTY_TOP * aldim_pkg::GREEN_NUM / aldim_pkg::RATIO_DEN) / 2;
   localparam int CONST_BLUE  = (DUTY_TOP * aldim_pkg::BLUE_NUM / aldim_pkg::RATIO_DEN) / 2;
   localparam int CONST_PCT   = CONST_RED * aldim_pkg::PCT_SCALE / DUTY_TOP;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_RAW,
      ST_SLEW,
      ST_RED,
      ST_GREEN_GO,
      ST_GREEN,
      ST_PCT_GO,
      ST_PCT,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [6:0]         dark_ff, dark_in;
   logic [6:0]         bright_ff, bright_in;
   logic [6:0]         win_ff, win_in;
   logic [6:0]         step_ff, step_in;
   logic [1:0]         mode_ff, mode_in;
   logic [6:0]         lv_ff, lv_in;
   logic [6:0]         shown_ff, shown_in;
   logic [6:0]         held_ff, held_in;
   logic [RW-1:0]      breath_ff, breath_in;
   logic               rising_ff, rising_in;
   logic [RW-1:0]      red_ff, red_in;
   logic [RW-1:0]      green_ff, green_in;
   logic [RW-1:0]      blue_ff, blue_in;
   logic [6:0]         pct_ff, pct_in;
   logic               rsp_valid_ff, rsp_valid_in;
   aldim_pkg::rsp_type rsp_ff, rsp_in;

   logic               unit_start;
   logic [RW-1:0]      unit_a;
   logic [MW-1:0]      unit_m;
   logic [DW-1:0]      unit_d;
   logic               unit_busy;
   logic               unit_done;
   logic [PW-1:0]      unit_q;

   logic [6:0]         raw;
   logic [7:0]         held_hi;
   logic [BW-1:0]      breath_sum;

   aldim_muldiv #(
      .AW(RW),
      .MW(MW),
      .DW(DW)
   ) u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .start    (unit_start),
      .op_a     (unit_a),
      .op_m     (unit_m),
      .op_d     (unit_d),
      .busy     (unit_busy),
      .done     (unit_done),
      .quotient (unit_q)
   );

   assign raw        = 7'(unit_q);
   assign held_hi    = 8'(held_ff) + 8'(win_ff);
   assign breath_sum = BW'(breath_ff) + BW'(step_ff);

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      dark_in      = dark_ff;
      bright_in    = bright_ff;
      win_in       = win_ff;
      step_in      = step_ff;
      mode_in      = mode_ff;
      lv_in        = lv_ff;
      shown_in     = shown_ff;
      held_in      = held_ff;
      breath_in    = breath_ff;
      rising_in    = rising_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      pct_in       = pct_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      unit_start   = 1'b0;
      unit_a       = '0;
      unit_m       = '0;
      unit_d       = '0;

      // configuration writes
      if (csr_we) begin
         case (csr_addr)
            aldim_pkg::CSR_DARK_LEVEL:   dark_in   = csr_wdata;
            aldim_pkg::CSR_BRIGHT_LEVEL: bright_in = csr_wdata;
            aldim_pkg::CSR_HYST_WINDOW:  win_in    = csr_wdata;
            aldim_pkg::CSR_BREATH_STEP:  step_in   = csr_wdata;
            default: ;
         endcase
      end

      // output register drains on transfer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               lv_in    = req_data.light_level;
               state_in = ST_DISPATCH;
               if (req_data.mode_button) begin
                  case (mode_ff)
                     aldim_pkg::MODE_SENSE: mode_in = aldim_pkg::MODE_CONST;
                     aldim_pkg::MODE_CONST: mode_in = aldim_pkg::MODE_RAMP;
                     default:               mode_in = aldim_pkg::MODE_SENSE;
                  endcase
               end
            end
         end

         ST_DISPATCH: begin
            case (mode_ff)
               aldim_pkg::MODE_SENSE: begin
                  if (lv_ff >= bright_ff) begin
                     held_in  = '0;
                     state_in = ST_SLEW;
                  end else if (lv_ff <= dark_ff) begin
                     held_in  = aldim_pkg::PCT_FULL;
                     state_in = ST_SLEW;
                  end else begin
                     // linear region: (lv - dark) * 100 / (bright - dark)
                     unit_start = 1'b1;
                     unit_a     = RW'(lv_ff - dark_ff);
                     unit_m     = MW'(aldim_pkg::PCT_SCALE);
                     unit_d     = DW'(bright_ff - dark_ff);
                     state_in   = ST_RAW;
                  end
               end
               aldim_pkg::MODE_CONST: begin
                  red_in   = RW'(CONST_RED);
                  green_in = RW'(CONST_GREEN);
                  blue_in  = RW'(CONST_BLUE);
                  pct_in   = 7'(CONST_PCT);
                  state_in = ST_DONE;
               end
               aldim_pkg::MODE_RAMP: begin
                  // triangle ramp, clamped at both ends
                  if (rising_ff) begin
                     if (breath_sum >= BW'(DUTY_TOP)) begin
                        breath_in = RW'(DUTY_TOP);
                        rising_in = 1'b0;
                     end else begin
                        breath_in = RW'(breath_sum);
                     end
                  end else if (BW'(breath_ff) <= BW'(step_ff)) begin
                     breath_in = '0;
                     rising_in = 1'b1;
                  end else begin
                     breath_in = breath_ff - RW'(step_ff);
                  end
                  red_in   = breath_in;
                  state_in = ST_GREEN_GO;
               end
               default: begin
                  state_in = ST_PCT_GO;
               end
            endcase
         end

         ST_RAW: begin
            if (unit_done) begin
               // hysteresis: accept only moves outside held +/- window
               if ((8'(raw) > held_hi) || ((8'(raw) + 8'(win_ff)) < 8'(held_ff))) begin
                  held_in = raw;
               end
               state_in = ST_SLEW;
            end
         end

         ST_SLEW: begin
            if (held_ff > shown_ff) begin
               shown_in = shown_ff + 7'd1;
            end else if (held_ff < shown_ff) begin
               shown_in = shown_ff - 7'd1;
            end
            // red = shown * DUTY_TOP / 100
            unit_start = 1'b1;
            unit_a     = RW'(shown_in);
            unit_m     = MW'(DUTY_TOP);
            unit_d     = DW'(aldim_pkg::PCT_SCALE);
            state_in   = ST_RED;
         end

         ST_RED: begin
            if (unit_done) begin
               red_in   = RW'(unit_q);
               state_in = ST_GREEN_GO;
            end
         end

         ST_GREEN_GO: begin
            unit_start = 1'b1;
            unit_a     = red_ff;
            unit_m     = MW'(aldim_pkg::GREEN_NUM);
            unit_d     = DW'(aldim_pkg::RATIO_DEN);
            state_in   = ST_GREEN;
         end

         ST_GREEN: begin
            if (unit_done) begin
               // blue ratio is exactly half the green ratio, so floor halves too
               green_in = RW'(unit_q);
               blue_in  = RW'(unit_q[PW-1:1]);
               if (mode_ff == aldim_pkg::MODE_SENSE) begin
                  pct_in   = shown_ff;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_PCT_GO;
               end
            end
         end

         ST_PCT_GO: begin
            unit_start = 1'b1;
            unit_a     = red_ff;
            unit_m     = MW'(aldim_pkg::PCT_SCALE);
            unit_d     = DW'(DUTY_TOP);
            state_in   = ST_PCT;
         end

         ST_PCT: begin
            if (unit_done) begin
               pct_in   = 7'(unit_q);
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.red_duty      = 10'(red_ff);
               rsp_in.green_duty    = 10'(green_ff);
               rsp_in.blue_duty     = 10'(blue_ff);
               rsp_in.active_mode   = mode_ff;
               rsp_in.level_percent = pct_ff;
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      lv_ff  <= lv_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         dark_ff      <= aldim_pkg::DARK_LEVEL_RST;
         bright_ff    <= aldim_pkg::BRIGHT_LEVEL_RST;
         win_ff       <= aldim_pkg::HYST_WINDOW_RST;
         step_ff      <= aldim_pkg::BREATH_STEP_RST;
         mode_ff      <= aldim_pkg::MODE_SENSE;
         shown_ff     <= '0;
         held_ff      <= '0;
         breath_ff    <= '0;
         rising_ff    <= 1'b1;
         red_ff       <= '0;
         green_ff     <= '0;
         blue_ff      <= '0;
         pct_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dark_ff      <= dark_in;
         bright_ff    <= bright_in;
         win_ff       <= win_in;
         step_ff      <= step_in;
         mode_ff      <= mode_in;
         shown_ff     <= shown_in;
         held_ff      <= held_in;
         breath_ff    <= breath_in;
         rising_ff    <= rising_in;
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         pct_ff       <= pct_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `ALD_ASSERT_NOW(a_unit_owned, unit_busy, (state_ff == ST_RAW || state_ff == ST_RED || state_ff == ST_GREEN || state_ff == ST_PCT))
   `ALD_ASSERT_NOW(a_done_awaited, unit_done, (state_ff == ST_RAW || state_ff == ST_RED || state_ff == ST_GREEN || state_ff == ST_PCT))
   `ALD_ASSERT_NOW(a_level_range, 1'b1, (held_ff <= aldim_pkg::PCT_FULL && shown_ff <= aldim_pkg::PCT_FULL))
   `ALD_ASSERT_NOW(a_breath_range, 1'b1, (breath_ff <= RW'(DUTY_TOP)))
   `ALD_ASSERT_NEXT(a_accept_dispatch, (req_valid && req_ready), (state_ff == ST_DISPATCH))

endmodule

/* tb/ambient_light_led_dimmer_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the ambient light LED dimmer: tracks CSR writes, predicts each frame's
// duties and mode, and compares every result transfer. Depends on aldim_pkg.
module ambient_light_led_dimmer_checker #(
   parameter int DUTY_TOP = 999
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  aldim_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  aldim_pkg::rsp_type rsp_data,
   input  logic               csr_we,
   input  logic [1:0]         csr_addr,
   input  logic [6:0]         csr_wdata,
   output int                 mismatch_count,
   output int                 frames_outstanding
);
   import aldim_pkg::*;

   localparam int PRINT_CAP = 50;

   // shadow configuration
   logic [6:0] dark_q, bright_q, window_q, step_q;
   // shadow frame state
   logic [1:0] mode_q;
   int         shown_q, target_q, breath_q;
   logic       rising_q;
   int         red_q, green_q, blue_q;

   rsp_type    expected_frames[$];
   rsp_type    want;

   initial begin
      mismatch_count     = 0;
      frames_outstanding = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int exp_val);
      if (mismatch_count < PRINT_CAP)
         $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp_val);
      mismatch_count++;
   endtask

   function automatic void load_warm(input int red);
      red_q   = red;
      green_q = red * GREEN_NUM / RATIO_DEN;
      blue_q  = red * BLUE_NUM / RATIO_DEN;
   endfunction

   // Advance the shadow state by one frame and return the duties it should produce
   function automatic rsp_type predict_frame(input req_type frame);
      rsp_type r;
      int      lv, raw, pct;
      lv = int'(frame.light_level);
      if (frame.mode_button)
         mode_q = (mode_q == MODE_RAMP) ? MODE_SENSE : mode_q + 2'd1;

      case (mode_q)
         MODE_SENSE: begin
            // cutoffs load the held target directly; middle region goes through hysteresis
            if (lv >= int'(bright_q)) begin
               target_q = 0;
            end else if (lv <= int'(dark_q)) begin
               target_q = int'(PCT_FULL);
            end else begin
               raw = (lv - int'(dark_q)) * PCT_SCALE / (int'(bright_q) - int'(dark_q));
               if (raw > target_q + int'(window_q) || raw < target_q - int'(window_q))
                  target_q = raw;
            end
            // slew one step per frame
            if (target_q > shown_q)
               shown_q++;
            else if (target_q < shown_q)
               shown_q--;
            load_warm(shown_q * DUTY_TOP / PCT_SCALE);
         end
         MODE_CONST: begin
            red_q   = DUTY_TOP / 2;
            green_q = (DUTY_TOP * GREEN_NUM / RATIO_DEN) / 2;
            blue_q  = (DUTY_TOP * BLUE_NUM / RATIO_DEN) / 2;
         end
         MODE_RAMP: begin
            // triangle ramp, clamped at both ends
            if (rising_q) begin
               breath_q += int'(step_q);
               if (breath_q >= DUTY_TOP) begin
                  breath_q = DUTY_TOP;
                  rising_q = 1'b0;
               end
            end else if (breath_q <= int'(step_q)) begin
               breath_q = 0;
               rising_q = 1'b1;
            end else begin
               breath_q -= int'(step_q);
            end
            load_warm(breath_q);
         end
         default: ; // unreachable mode keeps the last duties
      endcase

      pct = (mode_q == MODE_SENSE) ? shown_q : red_q * PCT_SCALE / DUTY_TOP;
      r.red_duty      = 10'(red_q);
      r.green_duty    = 10'(green_q);
      r.blue_duty     = 10'(blue_q);
      r.active_mode   = mode_q;
      r.level_percent = 7'(pct);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         dark_q   = DARK_LEVEL_RST;
         bright_q = BRIGHT_LEVEL_RST;
         window_q = HYST_WINDOW_RST;
         step_q   = BREATH_STEP_RST;
         mode_q   = MODE_SENSE;
         shown_q  = 0;
         target_q = 0;
         breath_q = 0;
         rising_q = 1'b1;
         red_q    = 0;
         green_q  = 0;
         blue_q   = 0;
         expected_frames.delete();
      end else begin
         // CSR writes
         if (csr_we) begin
            case (csr_addr)
               CSR_DARK_LEVEL:   dark_q   = csr_wdata;
               CSR_BRIGHT_LEVEL: bright_q = csr_wdata;
               CSR_HYST_WINDOW:  window_q = csr_wdata;
               CSR_BREATH_STEP:  step_q   = csr_wdata;
               default: ;
            endcase
         end
         // frame transfer in
         if (req_valid && req_ready)
            expected_frames.push_back(predict_frame(req_data));
         // result transfer out
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               report_mismatch("result with no frame pending", rsp_data.red_duty, -1);
            end else begin
               want = expected_frames.pop_front();
               if (rsp_data.red_duty !== want.red_duty)
                  report_mismatch("red_duty", rsp_data.red_duty, want.red_duty);
               if (rsp_data.green_duty !== want.green_duty)
                  report_mismatch("green_duty", rsp_data.green_duty, want.green_duty);
               if (rsp_data.blue_duty !== want.blue_duty)
                  report_mismatch("blue_duty", rsp_data.blue_duty, want.blue_duty);
               if (rsp_data.active_mode !== want.active_mode)
                  report_mismatch("active_mode", rsp_data.active_mode, want.active_mode);
               if (rsp_data.level_percent !== want.level_percent)
                  report_mismatch("level_percent", rsp_data.level_percent,
                                  want.level_percent);
            end
         end
      end
      frames_outstanding <= expected_frames.size();
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Top of the dimmer testbench: clock, reset, CSR setup and frame stimulus with random
// idling on both channels. Depends on aldim_pkg, the dimmer RTL and the checker.
module tb_top;
   import aldim_pkg::*;

   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int FRAMES_PER_PHASE = 225;
   localparam int DRAIN_CYCLES     = 150;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_data;
   logic       csr_we;
   logic [1:0] csr_addr;
   logic [6:0] csr_wdata;

   int          mismatch_count;
   int          frames_outstanding;
   int          cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   logic [6:0]  cfg_dark = DARK_LEVEL_RST;
   logic [6:0]  cfg_bright = BRIGHT_LEVEL_RST;
   logic [6:0]  light_prev = 7'd50;

   ambient_light_led_dimmer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   ambient_light_led_dimmer_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data           (req_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_data           (rsp_data),
      .csr_we             (csr_we),
      .csr_addr           (csr_addr),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (mismatch_count),
      .frames_outstanding (frames_outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // One frame transfer; called right after a rising edge, returns at the accepting edge
   task automatic send_frame(input logic [6:0] light, input logic press);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_data.light_level <= light;
      req_data.mode_button <= press;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every frame has come back
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (frames_outstanding != 0);
   endtask

   task automatic write_config(input logic [6:0] dark, input logic [6:0] bright,
                               input logic [6:0] window, input logic [6:0] step);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_DARK_LEVEL;
      csr_wdata <= dark;
      @(posedge clock);
      csr_addr  <= CSR_BRIGHT_LEVEL;
      csr_wdata <= bright;
      @(posedge clock);
      csr_addr  <= CSR_HYST_WINDOW;
      csr_wdata <= window;
      @(posedge clock);
      csr_addr  <= CSR_BREATH_STEP;
      csr_wdata <= step;
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_dark   = dark;
      cfg_bright = bright;
   endtask

   // Ordered cutoffs with a modest window, a step from 1 to 100
   task automatic write_random_config();
      int dark;
      dark = $urandom_range(60);
      write_config(7'(dark), 7'(dark + 1 + $urandom_range(99 - dark)),
                   7'($urandom_range(20)), 7'($urandom_range(1, 100)));
   endtask

   // Half the time a slow random walk so hysteresis and slewing get exercised
   function automatic logic [6:0] next_light();
      int v;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 50) begin
         v = int'(light_prev) + int'($urandom_range(16)) - 8;
      end else if (pick < 80) begin
         v = $urandom_range(100);
      end else begin
         case ($urandom_range(5))
            0: v = 0;
            1: v = 100;
            2: v = cfg_dark;
            3: v = cfg_bright;
            4: v = int'(cfg_dark) + 1;
            default: v = int'(cfg_bright) - 1;
         endcase
      end
      if (v < 0) v = 0;
      if (v > 100) v = 100;
      light_prev = 7'(v);
      return light_prev;
   endfunction

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      csr_we    = 1'b0;
      csr_addr  = CSR_DARK_LEVEL;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // auto mode at reset settings: cutoffs, their edges, middle and hysteresis
      send_frame(7'd0, 1'b0);
      send_frame(7'd100, 1'b0);
      send_frame(7'd25, 1'b0);
      send_frame(7'd80, 1'b0);
      send_frame(7'd26, 1'b0);
      send_frame(7'd50, 1'b0);
      send_frame(7'd52, 1'b0);
      send_frame(7'd60, 1'b0);
      // constant, breathing, back to auto
      send_frame(7'd40, 1'b1);
      send_frame(7'd90, 1'b0);
      send_frame(7'd10, 1'b1);
      send_frame(7'd10, 1'b0);
      send_frame(7'd10, 1'b0);
      send_frame(7'd70, 1'b1);
      send_frame(7'd100, 1'b0);
      // zero breath step holds the ramp
      settle();
      write_config(DARK_LEVEL_RST, BRIGHT_LEVEL_RST, HYST_WINDOW_RST, 7'd0);
      send_frame(7'd30, 1'b1);
      send_frame(7'd30, 1'b1);
      send_frame(7'd30, 1'b0);
      send_frame(7'd30, 1'b0);
      // degenerate cutoffs: everything reads as bright
      settle();
      write_config(7'd0, 7'd0, 7'd0, 7'd100);
      send_frame(7'd30, 1'b1);
      send_frame(7'd0, 1'b0);

      // random phases, each with its own idling and settings
      for (int phase = 0; phase < 4; phase++) begin
         settle();
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
               write_config(7'd0, 7'd100, 7'd0, 7'd100);
            end
            1: begin
               send_idle_pct = 85;
               stall_pct     = 0;
               write_config(7'd100, 7'd0, 7'd100, 7'd1);
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 85;
               write_random_config();
            end
            default: begin
               send_idle_pct = 37;
               stall_pct     = 37;
               write_config(7'($urandom_range(100)), 7'($urandom_range(100)),
                            7'($urandom_range(100)), 7'($urandom_range(100)));
            end
         endcase
         for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
            if (i == FRAMES_PER_PHASE / 2) begin
               settle();
               write_random_config();
            end
            send_frame(next_light(), $urandom_range(99) < 6);
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
